[rtl/dpft_pkg.sv]
package dpft_pkg;

   // default formats: colour Q8.16, alpha Q1.16
   localparam int DEFAULT_FRACTION_BITS       = 16;
   localparam int DEFAULT_COLOUR_INTEGER_BITS = 8;

   // configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 17;

   localparam logic [CSR_DATA_W-1:0] OPAQUE_THRESHOLD_RESET    = 17'd65530;
   localparam logic [CSR_DATA_W-1:0] UNPREMULTIPLY_FLOOR_RESET = 17'd7;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_OPAQUE_THRESHOLD    = 2'd0,
      CSR_UNPREMULTIPLY_FLOOR = 2'd1
   } csr_index_type;

   // display conversion
   localparam int DISPLAY_W = 8;

   // flattened pixels waiting between front and back
   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef enum logic {
      FR_IDLE,
      FR_ACC
   } front_state_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_PREP,
      BK_LOAD,
      BK_DIV,
      BK_DONE
   } back_state_type;

   typedef enum logic [1:0] {
      CH_RED,
      CH_GREEN,
      CH_BLUE,
      CH_ALPHA
   } channel_type;

endpackage

[rtl/dpft_front.sv]
module dpft_front
   import dpft_pkg::*;
#(
   parameter int FRACTION_BITS       = DEFAULT_FRACTION_BITS,
   parameter int COLOUR_INTEGER_BITS = DEFAULT_COLOUR_INTEGER_BITS,
   localparam int CW = COLOUR_INTEGER_BITS + FRACTION_BITS,
   localparam int AW = FRACTION_BITS + 1,
   localparam int PIX_W = 3 * CW + AW
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [CW-1:0]         req_sample_red,
   input  logic [CW-1:0]         req_sample_green,
   input  logic [CW-1:0]         req_sample_blue,
   input  logic [AW-1:0]         req_sample_alpha,
   input  logic                  req_last_sample,
   input  logic                  req_empty_pixel,
   input  logic [CSR_DATA_W-1:0] opaque_threshold,
   input  queue_status_type      q_status,
   output logic                  q_push,
   output logic [PIX_W-1:0]      q_push_data
);

   localparam int F    = FRACTION_BITS;
   localparam int PCW  = CW + AW;
   localparam int PAW  = 2 * AW;
   localparam int CMPW = (AW > CSR_DATA_W) ? AW : CSR_DATA_W;

   localparam logic [AW-1:0]  ONE_A      = AW'(1) << F;
   localparam logic [CW-1:0]  COLOUR_MAX = {CW{1'b1}};
   localparam logic [PCW:0]   HALF_C     = (PCW+1)'(1) << (F - 1);
   localparam logic [PAW:0]   HALF_A     = (PAW+1)'(1) << (F - 1);

   // round the weighted colour, add, saturate at all ones
   function automatic logic [CW-1:0] add_colour(logic [CW-1:0] acc, logic [PCW-1:0] prod);
      logic [PCW:0]  rnd;
      logic [CW+2:0] sum;
      rnd = {1'b0, prod} + HALF_C;
      sum = (CW+3)'(acc) + (CW+3)'(rnd[PCW:F]);
      return (sum > (CW+3)'(COLOUR_MAX)) ? COLOUR_MAX : sum[CW-1:0];
   endfunction

   // round the weighted alpha, add, saturate at one
   function automatic logic [AW-1:0] add_alpha(logic [AW-1:0] acc, logic [PAW-1:0] prod);
      logic [PAW:0]  rnd;
      logic [AW+2:0] sum;
      rnd = {1'b0, prod} + HALF_A;
      sum = (AW+3)'(acc) + (AW+3)'(rnd[PAW:F]);
      return (sum > (AW+3)'(ONE_A)) ? ONE_A : sum[AW-1:0];
   endfunction

   front_state_type state_ff, state_in;

   logic [CW-1:0]  acc_red_ff, acc_green_ff, acc_blue_ff;
   logic [CW-1:0]  acc_red_in, acc_green_in, acc_blue_in;
   logic [AW-1:0]  acc_alpha_ff, acc_alpha_in;
   logic           opaque_ff, opaque_in;

   logic [PCW-1:0] prod_red_ff, prod_green_ff, prod_blue_ff;
   logic [PAW-1:0] prod_alpha_ff;
   logic           do_acc_ff, emit_ff;

   logic           take;
   logic [AW-1:0]  weight;
   logic [AW-1:0]  sample_alpha_clamped;

   logic [CW-1:0]  new_red, new_green, new_blue;
   logic [AW-1:0]  new_alpha, sum_alpha;
   logic           new_opaque;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FR_IDLE: if (take) state_in = FR_ACC;
         FR_ACC:  state_in = FR_IDLE;
         default: state_in = FR_IDLE;
      endcase
   end

   // handshake and queue strobes
   always_comb begin
      req_stall = (state_ff != FR_IDLE) || q_status.full;
      take      = (state_ff == FR_IDLE) && req_valid && !q_status.full;
      q_push    = (state_ff == FR_ACC) && emit_ff;
   end

   // weight from what is already in front of this sample
   assign weight               = ONE_A - acc_alpha_ff;
   assign sample_alpha_clamped = (req_sample_alpha > ONE_A) ? ONE_A : req_sample_alpha;

   // accumulate stage
   always_comb begin
      sum_alpha  = add_alpha(acc_alpha_ff, prod_alpha_ff);
      new_red    = acc_red_ff;
      new_green  = acc_green_ff;
      new_blue   = acc_blue_ff;
      new_alpha  = acc_alpha_ff;
      new_opaque = opaque_ff;
      if (do_acc_ff) begin
         new_red   = add_colour(acc_red_ff, prod_red_ff);
         new_green = add_colour(acc_green_ff, prod_green_ff);
         new_blue  = add_colour(acc_blue_ff, prod_blue_ff);
         new_alpha = sum_alpha;
         if (CMPW'(sum_alpha) >= CMPW'(opaque_threshold)) begin
            new_alpha  = ONE_A;
            new_opaque = 1'b1;
         end
      end
      q_push_data = {new_red, new_green, new_blue, new_alpha};
   end

   // accumulator next value, cleared once the pixel leaves
   always_comb begin
      acc_red_in   = acc_red_ff;
      acc_green_in = acc_green_ff;
      acc_blue_in  = acc_blue_ff;
      acc_alpha_in = acc_alpha_ff;
      opaque_in    = opaque_ff;
      if (state_ff == FR_ACC) begin
         if (emit_ff) begin
            acc_red_in   = '0;
            acc_green_in = '0;
            acc_blue_in  = '0;
            acc_alpha_in = '0;
            opaque_in    = 1'b0;
         end else begin
            acc_red_in   = new_red;
            acc_green_in = new_green;
            acc_blue_in  = new_blue;
            acc_alpha_in = new_alpha;
            opaque_in    = new_opaque;
         end
      end
   end

   // control and accumulator registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FR_IDLE;
         acc_red_ff   <= '0;
         acc_green_ff <= '0;
         acc_blue_ff  <= '0;
         acc_alpha_ff <= '0;
         opaque_ff    <= 1'b0;
         do_acc_ff    <= 1'b0;
         emit_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_red_ff   <= acc_red_in;
         acc_green_ff <= acc_green_in;
         acc_blue_ff  <= acc_blue_in;
         acc_alpha_ff <= acc_alpha_in;
         opaque_ff    <= opaque_in;
         if (take) begin
            do_acc_ff <= !req_empty_pixel && !opaque_ff;
            emit_ff   <= req_last_sample || req_empty_pixel;
         end
      end
   end

   // multiply stage
   always_ff @(posedge clock) begin
      if (take) begin
         prod_red_ff   <= PCW'(req_sample_red) * PCW'(weight);
         prod_green_ff <= PCW'(req_sample_green) * PCW'(weight);
         prod_blue_ff  <= PCW'(req_sample_blue) * PCW'(weight);
         prod_alpha_ff <= PAW'(sample_alpha_clamped) * PAW'(weight);
      end
   end

endmodule

[rtl/dpft_queue.sv]
module dpft_queue
   import dpft_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output queue_status_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      if (pop)  rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      if (push && !pop)      count_in = count_ff + CNT_W'(1);
      else if (pop && !push) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_data;
   end

   assign pop_data     = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

[rtl/dpft_back.sv]
module dpft_back
   import dpft_pkg::*;
#(
   parameter int FRACTION_BITS       = DEFAULT_FRACTION_BITS,
   parameter int COLOUR_INTEGER_BITS = DEFAULT_COLOUR_INTEGER_BITS,
   localparam int CW = COLOUR_INTEGER_BITS + FRACTION_BITS,
   localparam int AW = FRACTION_BITS + 1,
   localparam int PIX_W = 3 * CW + AW
) (
   input  logic                  clock,
   input  logic                  reset,
   input  queue_status_type      q_status,
   input  logic [PIX_W-1:0]      q_pop_data,
   output logic                  q_pop,
   input  logic [CSR_DATA_W-1:0] unpremultiply_floor,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [CW-1:0]         rsp_flat_red,
   output logic [CW-1:0]         rsp_flat_green,
   output logic [CW-1:0]         rsp_flat_blue,
   output logic [AW-1:0]         rsp_flat_alpha,
   output logic [DISPLAY_W-1:0]  rsp_display_red,
   output logic [DISPLAY_W-1:0]  rsp_display_green,
   output logic [DISPLAY_W-1:0]  rsp_display_blue,
   output logic [DISPLAY_W-1:0]  rsp_display_alpha
);

   localparam int F    = FRACTION_BITS;
   localparam int DW   = CW + 1;
   localparam int NW   = CW + 10;
   localparam int ANW  = AW + 9;
   localparam int SW   = $clog2(DISPLAY_W);
   localparam int CMPW = (AW > CSR_DATA_W) ? AW : CSR_DATA_W;
   localparam logic [AW-1:0] ONE_A = AW'(1) << F;
   localparam logic [SW-1:0] LAST_STEP = SW'(DISPLAY_W - 1);

   back_state_type state_ff, state_in;

   logic [CW-1:0]        pix_red_ff, pix_green_ff, pix_blue_ff;
   logic [AW-1:0]        pix_alpha_ff;
   logic [DW-1:0]        den_ff;
   channel_type          ch_ff;
   logic [NW-1:0]        rem_ff;
   logic [NW-1:0]        dsh_ff;
   logic [DISPLAY_W-1:0] quo_ff;
   logic [SW-1:0]        step_ff;
   logic [DISPLAY_W-1:0] disp_ff [3];
   logic                 rsp_valid_ff;

   logic do_prep, do_load, do_step, do_emit, out_free, last_step;

   logic [AW-1:0]        base;
   logic [CW-1:0]        max_rg, max_rgb;
   logic [DW-1:0]        den_calc;
   logic [CW-1:0]        chan_val;
   logic [NW:0]          trial;
   logic [ANW-1:0]       alpha_num;
   logic [DISPLAY_W-1:0] alpha_disp;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign last_step = (step_ff == '0);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: if (!q_status.empty) state_in = BK_PREP;
         BK_PREP: state_in = BK_LOAD;
         BK_LOAD: state_in = BK_DIV;
         BK_DIV: begin
            if (last_step) state_in = (ch_ff == CH_BLUE) ? BK_DONE : BK_LOAD;
         end
         BK_DONE: if (out_free) state_in = BK_IDLE;
         default: state_in = BK_IDLE;
      endcase
   end

   // strobes
   always_comb begin
      q_pop   = (state_ff == BK_IDLE) && !q_status.empty;
      do_prep = (state_ff == BK_PREP);
      do_load = (state_ff == BK_LOAD);
      do_step = (state_ff == BK_DIV);
      do_emit = (state_ff == BK_DONE) && out_free;
   end

   // denominator: alpha or one, plus the largest channel when it overflows
   always_comb begin
      base     = (CMPW'(pix_alpha_ff) > CMPW'(unpremultiply_floor)) ? pix_alpha_ff : ONE_A;
      max_rg   = (pix_green_ff > pix_red_ff) ? pix_green_ff : pix_red_ff;
      max_rgb  = (pix_blue_ff > max_rg) ? pix_blue_ff : max_rg;
      den_calc = (max_rgb > CW'(base)) ? DW'(base) + DW'(max_rgb) : DW'(base);
   end

   // display alpha: (510*a + one) / (2*one) is a plain shift
   always_comb begin
      alpha_num  = (ANW'(pix_alpha_ff) << 9) - (ANW'(pix_alpha_ff) << 1) + ANW'(ONE_A);
      alpha_disp = alpha_num[F+1 +: DISPLAY_W];
   end

   // channel being divided
   always_comb begin
      unique case (ch_ff)
         CH_RED:   chan_val = pix_red_ff;
         CH_GREEN: chan_val = pix_green_ff;
         CH_BLUE:  chan_val = pix_blue_ff;
         default:  chan_val = pix_red_ff;
      endcase
   end

   // one quotient bit per cycle
   assign trial = {1'b0, rem_ff} - {1'b0, dsh_ff};

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (do_emit) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (q_pop) begin
         {pix_red_ff, pix_green_ff, pix_blue_ff, pix_alpha_ff} <= q_pop_data;
      end
      if (do_prep) begin
         den_ff <= den_calc;
         ch_ff  <= CH_RED;
      end
      // numerator 510*c + den, divisor 2*den aligned to the top quotient bit
      if (do_load) begin
         rem_ff  <= (NW'(chan_val) << 9) - (NW'(chan_val) << 1) + NW'(den_ff);
         dsh_ff  <= NW'(den_ff) << DISPLAY_W;
         quo_ff  <= '0;
         step_ff <= LAST_STEP;
      end
      if (do_step) begin
         if (!trial[NW]) rem_ff <= trial[NW-1:0];
         dsh_ff  <= dsh_ff >> 1;
         quo_ff  <= {quo_ff[DISPLAY_W-2:0], !trial[NW]};
         step_ff <= step_ff - SW'(1);
         if (last_step) begin
            disp_ff[ch_ff] <= {quo_ff[DISPLAY_W-2:0], !trial[NW]};
            if (ch_ff != CH_BLUE) ch_ff <= channel_type'(2'(ch_ff) + 2'd1);
         end
      end
      if (do_emit) begin
         rsp_flat_red      <= pix_red_ff;
         rsp_flat_green    <= pix_green_ff;
         rsp_flat_blue     <= pix_blue_ff;
         rsp_flat_alpha    <= pix_alpha_ff;
         rsp_display_red   <= disp_ff[CH_RED];
         rsp_display_green <= disp_ff[CH_GREEN];
         rsp_display_blue  <= disp_ff[CH_BLUE];
         rsp_display_alpha <= alpha_disp;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[rtl/deep_pixel_flatten_tonemap_top.sv]
// channel  direction  handshake          beat
// req_     in         valid / stall      one premultiplied deep sample or empty marker
// rsp_     out        valid / stall      one flattened pixel with 8-bit display values
// csr_     in         valid / ready      one register write (index, data)
//
// front: multiply, then accumulate, one sample at a time (the new alpha sets the next weight)
// back: three colour divisions per pixel on one restoring divider, 1 bit a cycle
// a 2-entry queue of flattened pixels sits between front and back
// reset is synchronous: accumulators and queue clear, registers take their defaults
// rsp_stall holds the result register; the back then waits, the front runs on until the queue fills
module deep_pixel_flatten_tonemap_top
   import dpft_pkg::*;
#(
   parameter int FRACTION_BITS       = DEFAULT_FRACTION_BITS,
   parameter int COLOUR_INTEGER_BITS = DEFAULT_COLOUR_INTEGER_BITS,
   localparam int CW = COLOUR_INTEGER_BITS + FRACTION_BITS,
   localparam int AW = FRACTION_BITS + 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [CW-1:0]          req_sample_red,
   input  logic [CW-1:0]          req_sample_green,
   input  logic [CW-1:0]          req_sample_blue,
   input  logic [AW-1:0]          req_sample_alpha,
   input  logic                   req_last_sample,
   input  logic                   req_empty_pixel,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [CW-1:0]          rsp_flat_red,
   output logic [CW-1:0]          rsp_flat_green,
   output logic [CW-1:0]          rsp_flat_blue,
   output logic [AW-1:0]          rsp_flat_alpha,
   output logic [DISPLAY_W-1:0]   rsp_display_red,
   output logic [DISPLAY_W-1:0]   rsp_display_green,
   output logic [DISPLAY_W-1:0]   rsp_display_blue,
   output logic [DISPLAY_W-1:0]   rsp_display_alpha,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int PIX_W = 3 * CW + AW;

   logic [CSR_DATA_W-1:0] opaque_threshold_ff;
   logic [CSR_DATA_W-1:0] unpremultiply_floor_ff;

   queue_status_type q_status;
   logic             q_push, q_pop;
   logic [PIX_W-1:0] q_push_data, q_pop_data;

   // configuration registers, always ready
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         opaque_threshold_ff    <= OPAQUE_THRESHOLD_RESET;
         unpremultiply_floor_ff <= UNPREMULTIPLY_FLOOR_RESET;
      end else if (csr_valid) begin
         if (csr_index == CSR_OPAQUE_THRESHOLD) opaque_threshold_ff <= csr_data;
         else if (csr_index == CSR_UNPREMULTIPLY_FLOOR) unpremultiply_floor_ff <= csr_data;
      end
   end

   // sample accumulation
   dpft_front #(
      .FRACTION_BITS       (FRACTION_BITS),
      .COLOUR_INTEGER_BITS (COLOUR_INTEGER_BITS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample_red   (req_sample_red),
      .req_sample_green (req_sample_green),
      .req_sample_blue  (req_sample_blue),
      .req_sample_alpha (req_sample_alpha),
      .req_last_sample  (req_last_sample),
      .req_empty_pixel  (req_empty_pixel),
      .opaque_threshold (opaque_threshold_ff),
      .q_status         (q_status),
      .q_push           (q_push),
      .q_push_data      (q_push_data)
   );

   // flattened pixel queue
   dpft_queue #(
      .WIDTH (PIX_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .status    (q_status)
   );

   // display conversion
   dpft_back #(
      .FRACTION_BITS       (FRACTION_BITS),
      .COLOUR_INTEGER_BITS (COLOUR_INTEGER_BITS)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .q_status            (q_status),
      .q_pop_data          (q_pop_data),
      .q_pop               (q_pop),
      .unpremultiply_floor (unpremultiply_floor_ff),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_flat_red        (rsp_flat_red),
      .rsp_flat_green      (rsp_flat_green),
      .rsp_flat_blue       (rsp_flat_blue),
      .rsp_flat_alpha      (rsp_flat_alpha),
      .rsp_display_red     (rsp_display_red),
      .rsp_display_green   (rsp_display_green),
      .rsp_display_blue    (rsp_display_blue),
      .rsp_display_alpha   (rsp_display_alpha)
   );

endmodule
